// ----- hdl/ersof_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ersof_pkg;

  // Fixed formats of the block.
  localparam int TIME_BITS = 48;
  localparam int FRAC_BITS = 16;
  localparam int MIN_W     = 16;
  localparam int GS_W      = 8;
  localparam int CUT_W     = 24;
  localparam int RATE_W    = 40;
  localparam int TOTAL_W   = 32;
  localparam int IDX_W     = 2;
  localparam int CFG_W     = 24;

  // Shared divider: 64-bit dividend, 48-bit divisor, one quotient bit per cycle.
  localparam int DIV_W     = 64;
  localparam int DVS_W     = 48;
  localparam int DIV_CNT_W = 6;

  localparam logic [MIN_W-1:0]     MIN_RST   = 16'd1000;
  localparam logic [GS_W-1:0]      GS_RST    = 8'd5;
  localparam logic [CUT_W-1:0]     CUT_RST   = 24'd655;
  localparam logic [TIME_BITS-1:0] PREV_RST  = 48'd1000;
  localparam logic [19:0]          US_PER_S  = 20'd1000000;
  localparam logic [16:0]          DAMP_Q16  = 17'd92668;
  localparam logic [38:0]          STEP_CAP  = '1;
  localparam logic [RATE_W-1:0]    RAW_MAX   = '1;
  localparam logic [RATE_W-1:0]    FILT_MAX  = 40'h7F_FFFF_FFFF;
  localparam logic [RATE_W-1:0]    FILT_MIN  = 40'h80_0000_0000;

  // Division by one million as a shift by 6 and a division by 15625, the latter
  // done by a reciprocal multiply with one correction step.
  localparam logic [13:0]          US_ODD    = 14'd15625;
  localparam logic [23:0]          ALPHA_RCP = 24'd8796093;
  localparam logic [62:0]          ALPHA_SAT = 63'd8388608000000;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_INTERVAL = 2'd0,
    REG_GROUP_SIZE   = 2'd1,
    REG_CUTOFF       = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_EDGE,
    OP_DIV_RATE,
    OP_ALPHA_MUL,
    OP_ALPHA_EST,
    OP_ALPHA_FIX,
    OP_DEN_MUL,
    OP_DEN_SUM,
    OP_DIV_RATIO,
    OP_DIV_G0,
    OP_DIV_G1,
    OP_DIV_G2,
    OP_MAC0,
    OP_MAC1,
    OP_MAC2,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EDGE,
    ST_RATE,
    ST_ALPHA_MUL,
    ST_ALPHA_EST,
    ST_ALPHA_FIX,
    ST_DEN_MUL,
    ST_DEN_SUM,
    ST_RATIO,
    ST_G0,
    ST_G1,
    ST_G2,
    ST_DIV_WAIT,
    ST_MAC0,
    ST_MAC1,
    ST_MAC2,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_start;
  } ersof_cmd_t;

  typedef struct packed {
    logic group_done;
    logic div_done;
  } ersof_stat_t;

endpackage

`default_nettype wire

// ----- hdl/ersof_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ersof_in_if import ersof_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] edge_time_us;

  modport source (output valid, output edge_time_us, input ready);
  modport sink   (input valid, input edge_time_us, output ready);
endinterface

interface ersof_out_if import ersof_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [RATE_W-1:0]        raw_rate;
  logic signed [RATE_W-1:0] filtered_rate;
  logic [TOTAL_W-1:0]       accepted_pulses;

  modport source (output valid, output raw_rate, output filtered_rate,
                  output accepted_pulses, input ready);
  modport sink   (input valid, input raw_rate, input filtered_rate,
                  input accepted_pulses, output ready);
endinterface

interface ersof_cfg_if import ersof_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/encoder_rate_second_order_filter_unit.sv -----
// An edge that does not close a group yields nothing; one that closes a group shows
//   its result after five passes of the shared divider and the filter update.
// Edges are taken one at a time: a new edge waits until the previous one is through,
//   and an edge that closes a group also waits until the previous result has been taken.
// Reset (rst_n, synchronous, active low) restores the register defaults and clears
//   the edge history, counters and filter state; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module encoder_rate_second_order_filter_unit import ersof_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ersof_in_if.sink    in_ch,
  ersof_out_if.source out_ch,
  ersof_cfg_if.sink   cfg_ch
);

  // The controller sequences one edge at a time through the datapath. Each
  // closed group runs the rate division, the step ratio and the three gains
  // through one shared restoring divider. The step factor alpha divides by a
  // constant, so it uses a reciprocal multiply and one correction step. A
  // three-term multiply-accumulate and rounding finish the filter update.

  ersof_cmd_t  cmd;
  ersof_stat_t st;

  // Configuration writes are taken at any time; they are only expected while
  // the block is idle, so no interlock is needed.
  assign cfg_ch.ready = 1'b1;

  ersof_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .st        (st)
  );

  // The result register lives in the datapath, so a new edge is taken while a
  // finished result still waits for its transfer.
  ersof_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_time   (in_ch.edge_time_us),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_raw   (out_ch.raw_rate),
    .out_filt  (out_ch.filtered_rate),
    .out_total (out_ch.accepted_pulses)
  );

endmodule

`default_nettype wire

// ----- hdl/ersof_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ersof_div import ersof_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DVS_W:0]       trial;
  logic                 fits;

  // Restoring division: a zero divisor yields an all-ones quotient.
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- hdl/ersof_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ersof_dp import ersof_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ersof_cmd_t           cmd,
  output ersof_stat_t               st,
  input  wire logic [TIME_BITS-1:0] in_time,
  input  wire logic                 cfg_we,
  input  wire logic [IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic [RATE_W-1:0]         out_raw,
  output logic signed [RATE_W-1:0]  out_filt,
  output logic [TOTAL_W-1:0]        out_total
);

  // Configuration and filter state.
  logic [MIN_W-1:0]         min_r, min_nxt;
  logic [GS_W-1:0]          gs_r, gs_nxt;
  logic [CUT_W-1:0]         cut_r, cut_nxt;
  logic                     seen_r, seen_nxt;
  logic [TIME_BITS-1:0]     last_r, last_nxt;
  logic [GS_W-1:0]          edges_r, edges_nxt;
  logic [TIME_BITS-1:0]     gstart_r, gstart_nxt;
  logic [TIME_BITS-1:0]     prev_r, prev_nxt;
  logic [RATE_W-1:0]        ol_r, ol_nxt;
  logic [RATE_W-1:0]        obl_r, obl_nxt;
  logic [TOTAL_W-1:0]       total_r, total_nxt;

  // Working registers of one measurement.
  logic [TIME_BITS-1:0]     t_r, t_nxt;
  logic [TIME_BITS-1:0]     span_r, span_nxt;
  logic [RATE_W-1:0]        raw_r, raw_nxt;
  logic [62:0]              prod_r, prod_nxt;
  logic [23:0]              qest_r, qest_nxt;
  logic [22:0]              alpha_r, alpha_nxt;
  logic [45:0]              a2_r, a2_nxt;
  logic [39:0]              damp_r, damp_nxt;
  logic [30:0]              den_r, den_nxt;
  logic [23:0]              ratio_r, ratio_nxt;
  logic [21:0]              g0_r, g0_nxt;
  logic [21:0]              g1_r, g1_nxt;
  logic [21:0]              g2_r, g2_nxt;
  logic signed [64:0]       acc_r, acc_nxt;
  dp_op_t                   dest_r, dest_nxt;
  logic [RATE_W-1:0]        res_raw_r, res_raw_nxt;
  logic [RATE_W-1:0]        res_filt_r, res_filt_nxt;
  logic [TOTAL_W-1:0]       res_total_r, res_total_nxt;

  logic [TIME_BITS-1:0]     gap;
  logic [GS_W-1:0]          need;
  logic [GS_W-1:0]          edges_inc;
  logic                     accept;
  logic [27:0]              edge_us;
  logic [38:0]              span_cap;
  logic                     alpha_big;
  logic [36:0]              alpha_y;
  logic [60:0]              alpha_est;
  logic [37:0]              alpha_rem;
  logic                     halve;
  logic [46:0]              now_s, old_s;
  logic [41:0]              n1;
  logic [46:0]              den_sum;
  logic [DIV_W-1:0]         dvd;
  logic [DVS_W-1:0]         dvs;
  logic                     div_done;
  logic [DIV_W-1:0]         quo;
  logic signed [22:0]       mul_a;
  logic signed [40:0]       mul_b;
  logic signed [63:0]       mac_prod;
  logic [64:0]              neg_v, neg_rnd, pos_rnd;
  logic [48:0]              mag_neg, mag_pos;
  logic [RATE_W-1:0]        y;

  ersof_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    gap       = t_r - last_r;
    need      = (gs_r == '0) ? GS_W'(1) : gs_r;
    edges_inc = edges_r + 1'b1;
    accept    = seen_r && (gap >= TIME_BITS'(min_r));
    st.group_done = accept && (edges_inc >= need);
    st.div_done   = div_done;

    edge_us  = 28'(need) * 28'(US_PER_S);
    span_cap = (|span_r[TIME_BITS-1:39]) ? STEP_CAP : span_r[38:0];

    // Alpha is the product over one million, saturated. Below the saturation
    // point the product fits 43 bits, so the estimate is low by at most one.
    alpha_big = prod_r >= ALPHA_SAT;
    alpha_y   = prod_r[42:6];
    alpha_est = 61'(alpha_y) * 61'(ALPHA_RCP);
    alpha_rem = 38'(alpha_y) - 38'(qest_r) * 38'(US_ODD);

    halve    = span_r[TIME_BITS-1] | prev_r[TIME_BITS-1];
    now_s    = halve ? span_r[TIME_BITS-1:1] : span_r[46:0];
    old_s    = halve ? prev_r[TIME_BITS-1:1] : prev_r[46:0];
    n1       = 42'h1_0000_0000 + 42'({ratio_r, {FRAC_BITS{1'b0}}}) + 42'(damp_r);
    den_sum  = 47'h1_0000_0000 + 47'(damp_r) + 47'(a2_r);

    case (cmd.op)
      OP_DIV_RATE: begin
        dvd = DIV_W'({edge_us, {FRAC_BITS{1'b0}}});
        dvs = span_r;
      end
      OP_DIV_RATIO: begin
        dvd = DIV_W'({now_s, {FRAC_BITS{1'b0}}});
        dvs = DVS_W'(old_s);
      end
      OP_DIV_G0: begin
        dvd = DIV_W'(a2_r);
        dvs = DVS_W'(den_r);
      end
      OP_DIV_G1: begin
        dvd = DIV_W'(n1);
        dvs = DVS_W'(den_r);
      end
      OP_DIV_G2: begin
        dvd = DIV_W'({ratio_r, {FRAC_BITS{1'b0}}});
        dvs = DVS_W'(den_r);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase

    case (cmd.op)
      OP_MAC1: begin
        mul_a = signed'({1'b0, g1_r});
        mul_b = signed'({ol_r[RATE_W-1], ol_r});
      end
      OP_MAC2: begin
        mul_a = signed'({1'b0, g2_r});
        mul_b = signed'({obl_r[RATE_W-1], obl_r});
      end
      default: begin
        mul_a = signed'({1'b0, g0_r});
        mul_b = signed'({1'b0, raw_r});
      end
    endcase
    mac_prod = mul_a * mul_b;

    // Round half away from zero, then saturate to the signed output range.
    neg_v   = -acc_r;
    neg_rnd = neg_v + 65'd32768;
    pos_rnd = acc_r + 65'd32768;
    mag_neg = neg_rnd[64:FRAC_BITS];
    mag_pos = pos_rnd[64:FRAC_BITS];
    if (acc_r[64]) begin
      y = (mag_neg > 49'h80_0000_0000) ? FILT_MIN : RATE_W'(-mag_neg[RATE_W-1:0]);
    end else begin
      y = (|mag_pos[48:RATE_W-1]) ? FILT_MAX : mag_pos[RATE_W-1:0];
    end
  end

  always_comb begin
    min_nxt       = min_r;
    gs_nxt        = gs_r;
    cut_nxt       = cut_r;
    seen_nxt      = seen_r;
    last_nxt      = last_r;
    edges_nxt     = edges_r;
    gstart_nxt    = gstart_r;
    prev_nxt      = prev_r;
    ol_nxt        = ol_r;
    obl_nxt       = obl_r;
    total_nxt     = total_r;
    t_nxt         = t_r;
    span_nxt      = span_r;
    raw_nxt       = raw_r;
    prod_nxt      = prod_r;
    qest_nxt      = qest_r;
    alpha_nxt     = alpha_r;
    a2_nxt        = a2_r;
    damp_nxt      = damp_r;
    den_nxt       = den_r;
    ratio_nxt     = ratio_r;
    g0_nxt        = g0_r;
    g1_nxt        = g1_r;
    g2_nxt        = g2_r;
    acc_nxt       = acc_r;
    dest_nxt      = dest_r;
    res_raw_nxt   = res_raw_r;
    res_filt_nxt  = res_filt_r;
    res_total_nxt = res_total_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_MIN_INTERVAL: min_nxt = cfg_data[MIN_W-1:0];
        REG_GROUP_SIZE:   gs_nxt  = cfg_data[GS_W-1:0];
        REG_CUTOFF:       cut_nxt = cfg_data;
        default:          ;
      endcase
    end

    if (cmd.div_start) begin
      dest_nxt = cmd.op;
    end

    if (div_done) begin
      case (dest_r)
        OP_DIV_RATE:  raw_nxt   = (|quo[DIV_W-1:RATE_W]) ? RAW_MAX : quo[RATE_W-1:0];
        OP_DIV_RATIO: ratio_nxt = (|quo[DIV_W-1:24]) ? '1 : quo[23:0];
        OP_DIV_G0:    g0_nxt    = (|quo[DIV_W-1:22]) ? '1 : quo[21:0];
        OP_DIV_G1:    g1_nxt    = (|quo[DIV_W-1:22]) ? '1 : quo[21:0];
        OP_DIV_G2:    g2_nxt    = (|quo[DIV_W-1:22]) ? '1 : quo[21:0];
        default:      ;
      endcase
    end

    case (cmd.op)
      OP_LOAD: t_nxt = in_time;
      OP_EDGE: begin
        if (!seen_r) begin
          seen_nxt = 1'b1;
          last_nxt = t_r;
        end else if (accept) begin
          last_nxt  = t_r;
          total_nxt = total_r + 1'b1;
          if (st.group_done) begin
            edges_nxt  = '0;
            span_nxt   = t_r - gstart_r;
            gstart_nxt = t_r;
          end else begin
            edges_nxt = edges_inc;
          end
        end
      end
      OP_ALPHA_MUL: prod_nxt = 63'(cut_r) * 63'(span_cap);
      OP_ALPHA_EST: qest_nxt = alpha_est[60:37];
      OP_ALPHA_FIX: alpha_nxt = alpha_big ? '1 :
                                23'(qest_r + 24'(alpha_rem >= 38'(US_ODD)));
      OP_DEN_MUL: begin
        a2_nxt   = 46'(alpha_r) * 46'(alpha_r);
        damp_nxt = 40'(DAMP_Q16) * 40'(alpha_r);
      end
      OP_DEN_SUM: den_nxt = den_sum[46:FRAC_BITS];
      OP_MAC0:    acc_nxt = 65'(mac_prod);
      OP_MAC1:    acc_nxt = acc_r + 65'(mac_prod);
      OP_MAC2:    acc_nxt = acc_r - 65'(mac_prod);
      OP_FINISH: begin
        res_raw_nxt   = raw_r;
        res_filt_nxt  = y;
        res_total_nxt = total_r;
        obl_nxt       = ol_r;
        ol_nxt        = y;
        prev_nxt      = span_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= MIN_RST;
      gs_r    <= GS_RST;
      cut_r   <= CUT_RST;
      seen_r  <= 1'b0;
      last_r  <= '0;
      edges_r <= '0;
      gstart_r <= '0;
      prev_r  <= PREV_RST;
      ol_r    <= '0;
      obl_r   <= '0;
      total_r <= '0;
      dest_r  <= OP_NONE;
    end else begin
      min_r   <= min_nxt;
      gs_r    <= gs_nxt;
      cut_r   <= cut_nxt;
      seen_r  <= seen_nxt;
      last_r  <= last_nxt;
      edges_r <= edges_nxt;
      gstart_r <= gstart_nxt;
      prev_r  <= prev_nxt;
      ol_r    <= ol_nxt;
      obl_r   <= obl_nxt;
      total_r <= total_nxt;
      dest_r  <= dest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    span_r      <= span_nxt;
    raw_r       <= raw_nxt;
    prod_r      <= prod_nxt;
    qest_r      <= qest_nxt;
    alpha_r     <= alpha_nxt;
    a2_r        <= a2_nxt;
    damp_r      <= damp_nxt;
    den_r       <= den_nxt;
    ratio_r     <= ratio_nxt;
    g0_r        <= g0_nxt;
    g1_r        <= g1_nxt;
    g2_r        <= g2_nxt;
    acc_r       <= acc_nxt;
    res_raw_r   <= res_raw_nxt;
    res_filt_r  <= res_filt_nxt;
    res_total_r <= res_total_nxt;
  end

  assign out_raw   = res_raw_r;
  assign out_filt  = signed'(res_filt_r);
  assign out_total = res_total_r;

endmodule

`default_nettype wire

// ----- hdl/ersof_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ersof_ctrl import ersof_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output ersof_cmd_t       cmd,
  input  wire ersof_stat_t st
);

  ctrl_state_t state_r, state_nxt;
  ctrl_state_t ret_r, ret_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = OP_NONE;
    cmd.div_start = 1'b0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_EDGE;
        end
      end
      ST_EDGE: begin
        cmd.op    = OP_EDGE;
        state_nxt = st.group_done ? ST_RATE : ST_IDLE;
      end
      ST_RATE: begin
        cmd.op        = OP_DIV_RATE;
        cmd.div_start = 1'b1;
        ret_nxt       = ST_ALPHA_MUL;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_ALPHA_MUL: begin
        cmd.op    = OP_ALPHA_MUL;
        state_nxt = ST_ALPHA_EST;
      end
      ST_ALPHA_EST: begin
        cmd.op    = OP_ALPHA_EST;
        state_nxt = ST_ALPHA_FIX;
      end
      ST_ALPHA_FIX: begin
        cmd.op    = OP_ALPHA_FIX;
        state_nxt = ST_DEN_MUL;
      end
      ST_DEN_MUL: begin
        cmd.op    = OP_DEN_MUL;
        state_nxt = ST_DEN_SUM;
      end
      ST_DEN_SUM: begin
        cmd.op    = OP_DEN_SUM;
        state_nxt = ST_RATIO;
      end
      ST_RATIO: begin
        cmd.op        = OP_DIV_RATIO;
        cmd.div_start = 1'b1;
        ret_nxt       = ST_G0;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_G0: begin
        cmd.op        = OP_DIV_G0;
        cmd.div_start = 1'b1;
        ret_nxt       = ST_G1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_G1: begin
        cmd.op        = OP_DIV_G1;
        cmd.div_start = 1'b1;
        ret_nxt       = ST_G2;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_G2: begin
        cmd.op        = OP_DIV_G2;
        cmd.div_start = 1'b1;
        ret_nxt       = ST_MAC0;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (st.div_done) begin
          state_nxt = ret_r;
        end
      end
      ST_MAC0: begin
        cmd.op    = OP_MAC0;
        state_nxt = ST_MAC1;
      end
      ST_MAC1: begin
        cmd.op    = OP_MAC1;
        state_nxt = ST_MAC2;
      end
      ST_MAC2: begin
        cmd.op    = OP_MAC2;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FINISH) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  a_div_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished while controller not waiting");

  a_load_then_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EDGE))
    else $error("accepted edge not evaluated next cycle");
`endif

endmodule

`default_nettype wire
